// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL. Both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define APDE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define APDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/apde_pkg.sv =====
package apde_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned APDE_TIME_BITS = 32;
  localparam int unsigned APDE_FRAC_BITS = 16;

  // Integer microsecond results are 24 bits
  localparam int unsigned US_W = 24;
  localparam logic [US_W-1:0] US_MAX = '1;

  // Gaps are capped at 2^38 us before the stall compare
  localparam int unsigned RAW_CAP_LOG2 = 38;

  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;

  localparam logic [11:0] CFG_RST_STALL_MULT = 12'd1024;
  localparam logic [23:0] CFG_RST_STALL_ABS  = 24'd500000;
  localparam logic [15:0] CFG_RST_ALPHA      = 16'd6554;
  localparam logic [11:0] CFG_RST_JGAIN      = 12'd512;
  localparam logic [23:0] CFG_RST_MIN_DELAY  = 24'd20000;
  localparam logic [23:0] CFG_RST_MAX_DELAY  = 24'd300000;
  localparam logic [15:0] CFG_RST_STEP_FRAC  = 16'd16384;
  localparam logic [23:0] CFG_RST_ANCHOR     = 24'd100000;

  typedef enum logic [2:0] {
    REG_STALL_MULT = 3'd0,
    REG_STALL_ABS  = 3'd1,
    REG_ALPHA      = 3'd2,
    REG_JGAIN      = 3'd3,
    REG_MIN_DELAY  = 3'd4,
    REG_MAX_DELAY  = 3'd5,
    REG_STEP_FRAC  = 3'd6,
    REG_ANCHOR     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [11:0] stall_mult;
    logic [23:0] stall_abs;
    logic [15:0] alpha;
    logic [11:0] jgain;
    logic [23:0] min_delay;
    logic [23:0] max_delay;
    logic [15:0] step_frac;
    logic [23:0] anchor;
  } cfg_t;

  typedef enum logic [2:0] {
    CLS_BASELINE = 3'd0,
    CLS_IGNORED  = 3'd1,
    CLS_STALL    = 3'd2,
    CLS_MEASURED = 3'd3,
    CLS_CLEARED  = 3'd4
  } cls_t;

  // Datapath step commands
  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,
    OP_LOAD  = 4'd1,
    OP_CHECK = 4'd2,
    OP_THR   = 4'd3,
    OP_STALL = 4'd4,
    OP_SMI   = 4'd5,
    OP_SMJ   = 4'd6,
    OP_TGTM  = 4'd7,
    OP_TGT   = 4'd8,
    OP_STEP  = 4'd9,
    OP_EMIT  = 4'd10
  } op_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic term;        // item finishes at the check step
    logic first;       // no interval known yet
    logic stall;       // gap exceeds the stall threshold
    logic have_delay;  // a measured delay exists
  } st_t;

endpackage

// ===== rtl/core/apde_regs.sv =====
module apde_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [apde_pkg::CFG_AW-1:0]  paddr,
  input  logic [apde_pkg::CFG_DW-1:0]  pwdata,
  output logic [apde_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  output apde_pkg::cfg_t               cfg
);
  import apde_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stall_mult <= CFG_RST_STALL_MULT;
      cfg_r.stall_abs  <= CFG_RST_STALL_ABS;
      cfg_r.alpha      <= CFG_RST_ALPHA;
      cfg_r.jgain      <= CFG_RST_JGAIN;
      cfg_r.min_delay  <= CFG_RST_MIN_DELAY;
      cfg_r.max_delay  <= CFG_RST_MAX_DELAY;
      cfg_r.step_frac  <= CFG_RST_STEP_FRAC;
      cfg_r.anchor     <= CFG_RST_ANCHOR;
    end else if (wr_en) begin
      case (idx)
        REG_STALL_MULT: cfg_r.stall_mult <= pwdata[11:0];
        REG_STALL_ABS:  cfg_r.stall_abs  <= pwdata[23:0];
        REG_ALPHA:      cfg_r.alpha      <= pwdata[15:0];
        REG_JGAIN:      cfg_r.jgain      <= pwdata[11:0];
        REG_MIN_DELAY:  cfg_r.min_delay  <= pwdata[23:0];
        REG_MAX_DELAY:  cfg_r.max_delay  <= pwdata[23:0];
        REG_STEP_FRAC:  cfg_r.step_frac  <= pwdata[15:0];
        REG_ANCHOR:     cfg_r.anchor     <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_STALL_MULT: prdata = CFG_DW'(cfg_r.stall_mult);
      REG_STALL_ABS:  prdata = CFG_DW'(cfg_r.stall_abs);
      REG_ALPHA:      prdata = CFG_DW'(cfg_r.alpha);
      REG_JGAIN:      prdata = CFG_DW'(cfg_r.jgain);
      REG_MIN_DELAY:  prdata = CFG_DW'(cfg_r.min_delay);
      REG_MAX_DELAY:  prdata = CFG_DW'(cfg_r.max_delay);
      REG_STEP_FRAC:  prdata = CFG_DW'(cfg_r.step_frac);
      REG_ANCHOR:     prdata = CFG_DW'(cfg_r.anchor);
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/apde_ctrl.sv =====
module apde_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  apde_pkg::st_t  st,
  output apde_pkg::op_t  cmd
);
  import apde_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_THR,
    S_STALL,
    S_SMI,
    S_SMJ,
    S_TGTM,
    S_TGT,
    S_STEP,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd       = OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd       = OP_CHECK;
        state_nxt = st.term ? S_EMIT : (st.first ? S_TGTM : S_THR);
      end
      S_THR: begin
        cmd       = OP_THR;
        state_nxt = S_STALL;
      end
      S_STALL: begin
        cmd       = OP_STALL;
        state_nxt = st.stall ? S_EMIT : S_SMI;
      end
      S_SMI: begin
        cmd       = OP_SMI;
        state_nxt = S_SMJ;
      end
      S_SMJ: begin
        cmd       = OP_SMJ;
        state_nxt = S_TGTM;
      end
      S_TGTM: begin
        cmd       = OP_TGTM;
        state_nxt = S_TGT;
      end
      S_TGT: begin
        cmd       = OP_TGT;
        state_nxt = st.have_delay ? S_STEP : S_EMIT;
      end
      S_STEP: begin
        cmd       = OP_STEP;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // wait for the output register to free up
        if (!out_valid_r || out_tready) begin
          cmd       = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = (cmd == OP_EMIT) | (out_valid_r & ~out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// ===== rtl/core/apde_dp.sv =====
module apde_dp #(
  parameter int unsigned TIME_BITS = apde_pkg::APDE_TIME_BITS,
  parameter int unsigned FRAC_BITS = apde_pkg::APDE_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  apde_pkg::op_t               cmd,
  output apde_pkg::st_t               st,
  input  apde_pkg::cfg_t              cfg,
  input  logic                        in_req,
  input  logic [TIME_BITS-1:0]        in_time,
  output logic [apde_pkg::US_W-1:0]   out_delay,
  output logic                        out_delay_valid,
  output logic [apde_pkg::US_W-1:0]   out_interval,
  output logic [apde_pkg::US_W-1:0]   out_jitter,
  output apde_pkg::cls_t              out_class
);
  import apde_pkg::*;

  localparam int unsigned QW   = US_W + FRAC_BITS;      // smoothed values
  localparam int unsigned PW   = QW + 16;               // multiplier product
  localparam int unsigned CW   = RAW_CAP_LOG2 + 1;      // capped gap
  localparam int unsigned RW   = (TIME_BITS > CW) ? TIME_BITS : CW;
  localparam int unsigned CMPW = CW + FRAC_BITS;        // stall compare
  localparam int unsigned TGW  = QW + 9;                // target sum
  localparam logic [RW-1:0] RAW_CAP = RW'(1) << RAW_CAP_LOG2;

  // control flags
  logic hl_r, hl_nxt, hi_r, hi_nxt, hd_r, hd_nxt;
  // payload
  logic                 req_r, req_nxt;
  logic [TIME_BITS-1:0] t_r, t_nxt, last_r, last_nxt;
  logic [QW-1:0]        si_r, si_nxt, sj_r, sj_nxt;
  logic [US_W-1:0]      cur_r, cur_nxt, tgt_r, tgt_nxt;
  logic [CW-1:0]        rawc_r, rawc_nxt;
  logic [QW-1:0]        rawq_r, rawq_nxt, mag_r, mag_nxt, dj_r, dj_nxt;
  logic                 diri_r, diri_nxt, dirj_r, dirj_nxt;
  logic [PW-1:0]        prod_r, prod_nxt;
  cls_t                 cls_r, cls_nxt;
  logic [US_W-1:0]      od_r, od_nxt, oi_r, oi_nxt, oj_r, oj_nxt;
  logic                 odv_r, odv_nxt;
  cls_t                 ocl_r, ocl_nxt;

  // shared multiplier
  logic [15:0]          mul_a;
  logic [QW-1:0]        mul_b;

  // gap classification
  logic [TIME_BITS-1:0] raw;
  logic [RW-1:0]        raw_ext;
  logic [CW-1:0]        raw_c;
  logic [US_W-1:0]      raw_us;
  logic [QW-1:0]        raw_q;
  logic                 raw_bad;

  // stall threshold
  logic [CMPW-1:0]      thr_mul, thr_abs, thr, gap_q;

  // target and slew
  logic [QW-1:0]        inc;
  logic [TGW-1:0]       target;
  logic [TGW-FRAC_BITS-1:0] tgt_us;
  logic [US_W-1:0]      tgt_cl, max_step, step_lim, step_d;

  assign raw     = t_r - last_r;
  assign raw_bad = (raw == '0) || raw[TIME_BITS-1];
  assign raw_ext = RW'(raw);
  assign raw_c   = (raw_ext > RAW_CAP) ? CW'(RAW_CAP) : raw_ext[CW-1:0];
  assign raw_us  = (raw_c > CW'(US_MAX)) ? US_MAX : raw_c[US_W-1:0];
  assign raw_q   = {raw_us, {FRAC_BITS{1'b0}}};

  assign thr_mul = CMPW'(prod_r[PW-1:8]);
  assign thr_abs = CMPW'({cfg.stall_abs, {FRAC_BITS{1'b0}}});
  assign thr     = (thr_abs > thr_mul) ? thr_abs : thr_mul;
  assign gap_q   = {rawc_r, {FRAC_BITS{1'b0}}};

  assign inc     = prod_r[PW-1:16];
  assign target  = TGW'(si_r) + TGW'(prod_r[PW-1:8]);
  assign tgt_us  = target[TGW-1:FRAC_BITS];
  always_comb begin
    if (tgt_us < (TGW-FRAC_BITS)'(cfg.min_delay)) begin
      tgt_cl = cfg.min_delay;
    end else if (tgt_us > (TGW-FRAC_BITS)'(cfg.max_delay)) begin
      tgt_cl = cfg.max_delay;
    end else begin
      tgt_cl = tgt_us[US_W-1:0];
    end
  end

  assign max_step = prod_r[PW-1:16+FRAC_BITS];
  assign step_lim = (max_step < cfg.min_delay) ? cfg.min_delay : max_step;
  assign step_d   = (tgt_r >= cur_r) ? (tgt_r - cur_r) : (cur_r - tgt_r);

  // multiplier operand select, product registered every cycle
  always_comb begin
    case (cmd)
      OP_THR:   begin mul_a = {4'b0, cfg.stall_mult}; mul_b = si_r;  end
      OP_STALL: begin mul_a = cfg.alpha;               mul_b = mag_r; end
      OP_SMI:   begin mul_a = cfg.alpha;               mul_b = dj_r;  end
      OP_TGTM:  begin mul_a = {4'b0, cfg.jgain};       mul_b = sj_r;  end
      OP_TGT:   begin mul_a = cfg.step_frac;           mul_b = si_r;  end
      default:  begin mul_a = '0;                      mul_b = '0;    end
    endcase
  end
  assign prod_nxt = PW'(mul_a) * PW'(mul_b);

  assign st.term       = req_r || !hl_r || raw_bad;
  assign st.first      = !hi_r;
  assign st.stall      = gap_q > thr;
  assign st.have_delay = hd_r;

  always_comb begin
    hl_nxt   = hl_r;    hi_nxt   = hi_r;    hd_nxt   = hd_r;
    req_nxt  = req_r;   t_nxt    = t_r;     last_nxt = last_r;
    si_nxt   = si_r;    sj_nxt   = sj_r;    cur_nxt  = cur_r;
    tgt_nxt  = tgt_r;   rawc_nxt = rawc_r;  rawq_nxt = rawq_r;
    mag_nxt  = mag_r;   dj_nxt   = dj_r;    diri_nxt = diri_r;
    dirj_nxt = dirj_r;  cls_nxt  = cls_r;
    od_nxt   = od_r;    oi_nxt   = oi_r;    oj_nxt   = oj_r;
    odv_nxt  = odv_r;   ocl_nxt  = ocl_r;
    case (cmd)
      OP_LOAD: begin
        req_nxt = in_req;
        t_nxt   = in_time;
      end
      OP_CHECK: begin
        if (req_r) begin
          hl_nxt  = 1'b0;
          hi_nxt  = 1'b0;
          hd_nxt  = 1'b0;
          cls_nxt = CLS_CLEARED;
        end else if (!hl_r) begin
          hl_nxt   = 1'b1;
          last_nxt = t_r;
          cls_nxt  = CLS_BASELINE;
        end else if (raw_bad) begin
          cls_nxt = CLS_IGNORED;
        end else begin
          rawc_nxt = raw_c;
          rawq_nxt = raw_q;
          cls_nxt  = CLS_MEASURED;
          if (!hi_r) begin
            // first interval seeds the estimates
            si_nxt   = raw_q;
            sj_nxt   = '0;
            hi_nxt   = 1'b1;
            last_nxt = t_r;
          end
        end
      end
      OP_THR: begin
        diri_nxt = rawq_r >= si_r;
        mag_nxt  = (rawq_r >= si_r) ? (rawq_r - si_r) : (si_r - rawq_r);
      end
      OP_STALL: begin
        last_nxt = t_r;
        if (st.stall) begin
          hi_nxt  = 1'b0;
          hd_nxt  = 1'b0;
          cls_nxt = CLS_STALL;
        end else begin
          dirj_nxt = mag_r >= sj_r;
          dj_nxt   = (mag_r >= sj_r) ? (mag_r - sj_r) : (sj_r - mag_r);
        end
      end
      OP_SMI: si_nxt = diri_r ? (si_r + inc) : (si_r - inc);
      OP_SMJ: sj_nxt = dirj_r ? (sj_r + inc) : (sj_r - inc);
      OP_TGTM: ;
      OP_TGT: begin
        tgt_nxt = tgt_cl;
        if (!hd_r) begin
          cur_nxt = tgt_cl;
          hd_nxt  = 1'b1;
        end
      end
      OP_STEP: begin
        if (tgt_r >= cur_r) begin
          cur_nxt = cur_r + ((step_d > step_lim) ? step_lim : step_d);
        end else begin
          cur_nxt = cur_r - ((step_d > step_lim) ? step_lim : step_d);
        end
      end
      OP_EMIT: begin
        od_nxt  = hd_r ? cur_r : cfg.anchor;
        odv_nxt = hd_r;
        oi_nxt  = hi_r ? si_r[QW-1:FRAC_BITS] : '0;
        oj_nxt  = hi_r ? sj_r[QW-1:FRAC_BITS] : '0;
        ocl_nxt = cls_r;
      end
      OP_NONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hl_r <= 1'b0;
      hi_r <= 1'b0;
      hd_r <= 1'b0;
    end else begin
      hl_r <= hl_nxt;
      hi_r <= hi_nxt;
      hd_r <= hd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;   t_r    <= t_nxt;    last_r <= last_nxt;
    si_r   <= si_nxt;    sj_r   <= sj_nxt;   cur_r  <= cur_nxt;
    tgt_r  <= tgt_nxt;   rawc_r <= rawc_nxt; rawq_r <= rawq_nxt;
    mag_r  <= mag_nxt;   dj_r   <= dj_nxt;   diri_r <= diri_nxt;
    dirj_r <= dirj_nxt;  prod_r <= prod_nxt; cls_r  <= cls_nxt;
    od_r   <= od_nxt;    oi_r   <= oi_nxt;   oj_r   <= oj_nxt;
    odv_r  <= odv_nxt;   ocl_r  <= ocl_nxt;
  end

  assign out_delay       = od_r;
  assign out_delay_valid = odv_r;
  assign out_interval    = oi_r;
  assign out_jitter      = oj_r;
  assign out_class       = ocl_r;

endmodule

// ===== rtl/core/adaptive_playout_delay_estimator_core.sv =====
// Channel   Dir  Carries                                   Width
// in_*      in   req_type (tuser), arrival_time (tdata)    1 / TIME_BITS padded to bytes
// out_*     out  delay, valid, class (tuser), intervals    4 / 72
// cfg_*     in   8 config registers at byte address 4*i    32-bit APB
//
// Flow: one beat at a time; clear, baseline and ignored beats go load, check, emit; a
// first interval adds the target steps; a stall ends at the stall step; a steady beat runs
// every step, using the single shared 16 x (24+FRAC_BITS) multiplier at most once each.
// Reset: synchronous active-low rst_n; config returns to defaults, estimates drop.
// Stalls: a finished result waits in the output register; the next beat is
// taken meanwhile and held at its last step until that register frees up.
`include "assert_macros.svh"

module adaptive_playout_delay_estimator_core #(
  parameter int unsigned TIME_BITS = apde_pkg::APDE_TIME_BITS,
  parameter int unsigned FRAC_BITS = apde_pkg::APDE_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [TIME_BITS-1:0] arrival_time, zero padded
  input  logic [((TIME_BITS+7)/8)*8-1:0]      in_tdata,
  // [0] req_type
  input  logic [0:0]                          in_tuser,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [23:0] delay_us, [47:24] interval_us, [71:48] jitter_us
  output logic [71:0]                         out_tdata,
  // [0] delay_valid, [3:1] arrival_class
  output logic [3:0]                          out_tuser,
  // configuration
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [apde_pkg::CFG_AW-1:0]         cfg_paddr,
  input  logic [apde_pkg::CFG_DW-1:0]         cfg_pwdata,
  output logic [apde_pkg::CFG_DW-1:0]         cfg_prdata,
  output logic                                cfg_pready
);
  import apde_pkg::*;

  cfg_t            cfg;
  op_t             cmd;
  st_t             st;
  logic [US_W-1:0] delay, interval, jitter;
  logic            delay_valid;
  cls_t            arr_class;
  logic            clr_or_stall;
  logic            est_empty;

  apde_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // sequencer: one step command per cycle, none while it waits for a beat or the output register
  apde_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  // estimator state, shared multiplier and output register
  apde_dp #(
    .TIME_BITS (TIME_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .cfg             (cfg),
    .in_req          (in_tuser[0]),
    .in_time         (in_tdata[TIME_BITS-1:0]),
    .out_delay       (delay),
    .out_delay_valid (delay_valid),
    .out_interval    (interval),
    .out_jitter      (jitter),
    .out_class       (arr_class)
  );

  assign out_tdata = {jitter, interval, delay};
  assign out_tuser = {arr_class, delay_valid};

  // result beat after a clear or a stall, and an empty estimate set
  assign clr_or_stall = out_tvalid && (arr_class == CLS_CLEARED || arr_class == CLS_STALL);
  assign est_empty    = !delay_valid && interval == '0 && jitter == '0;

  // one beat in flight: an accepted beat drops ready until it is done
  `APDE_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready, "beat taken while busy")
  // the output register is only reloaded once it is free
  `APDE_ASSERT_IMPL(a_emit_free, cmd == OP_EMIT, !out_tvalid || out_tready, "result overwritten")
  // a clear or a stall leaves no measured estimate behind
  `APDE_ASSERT_IMPL(a_reset_class, clr_or_stall, est_empty, "estimate left after clear or stall")

endmodule

// ===== dv/tb_adaptive_playout_delay_estimator_core.sv =====
`timescale 1ns / 100ps

module tb_adaptive_playout_delay_estimator_core;
  import apde_pkg::*;

  // tdata width of the arrival side: TIME_BITS rounded up to whole bytes
  localparam int unsigned IN_DW = ((APDE_TIME_BITS + 7) / 8) * 8;
  localparam int unsigned FB = APDE_FRAC_BITS;

  // saturation limits of the estimator
  localparam logic [63:0] US_LIM  = 64'hFF_FFFF;
  localparam logic [63:0] Q_LIM   = (64'd1 << (24 + FB)) - 64'd1;
  localparam logic [63:0] GAP_CAP = 64'd1 << RAW_CAP_LOG2;

  // register profiles used across the run
  typedef enum int {
    PROF_DEFAULT,
    PROF_ZERO,
    PROF_FULL,
    PROF_INVERTED,
    PROF_RANDOM
  } cfg_profile_t;

  // one result beat, unpacked from out_tdata / out_tuser
  typedef struct packed {
    logic [23:0] delay;
    logic        valid;
    logic [23:0] interval;
    logic [23:0] jitter;
    cls_t        cls;
  } estimate_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_DW-1:0] in_tdata;   // [31:0] arrival_time
  logic [0:0]       in_tuser;   // [0] req_type
  logic             out_tvalid;
  logic             out_tready;
  logic [71:0]      out_tdata;  // [23:0] delay_us, [47:24] interval_us, [71:48] jitter_us
  logic [3:0]       out_tuser;  // [0] delay_valid, [3:1] arrival_class
  logic             cfg_psel;
  logic             cfg_penable;
  logic             cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic             cfg_pready;

  adaptive_playout_delay_estimator_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // ---------------------------------------------------------------------------
  // Estimator mirror: registers as written, plus the tracked arrival state.
  // Products and estimates are kept 64 bits wide so no intermediate product wraps.
  // ---------------------------------------------------------------------------
  cfg_t        live_cfg = '{stall_mult: CFG_RST_STALL_MULT, stall_abs: CFG_RST_STALL_ABS,
                            alpha: CFG_RST_ALPHA, jgain: CFG_RST_JGAIN,
                            min_delay: CFG_RST_MIN_DELAY, max_delay: CFG_RST_MAX_DELAY,
                            step_frac: CFG_RST_STEP_FRAC, anchor: CFG_RST_ANCHOR};
  bit          have_last = 1'b0;
  logic [31:0] last_t    = '0;
  bit          have_ivl  = 1'b0;
  logic [63:0] ivl_q     = '0;  // smoothed interval, FB fraction bits
  logic [63:0] jit_q     = '0;  // smoothed jitter, FB fraction bits
  bit          have_dly  = 1'b0;
  logic [63:0] dly_us    = '0;

  estimate_t   expected_estimates[$];

  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  int          mismatches = 0;
  int          beats_sent = 0;
  int          profiles_applied = 0;
  int          class_seen[5] = '{default: 0};
  logic [31:0] stream_t = '0;   // timestamp the generated stream builds on

  // floor(f * x / 2^16), split so the product stays inside 64 bits
  function automatic logic [63:0] scale_q16(logic [15:0] f, logic [63:0] x);
    return 64'(f) * (x >> 16) + ((64'(f) * (x & 64'hFFFF)) >> 16);
  endfunction

  // move v toward goal by floor(alpha * |goal - v| / 2^16)
  function automatic logic [63:0] smooth_toward(logic [63:0] v, logic [63:0] goal);
    if (goal >= v) return v + scale_q16(live_cfg.alpha, goal - v);
    return v - scale_q16(live_cfg.alpha, v - goal);
  endfunction

  function automatic void forget_estimates();
    have_ivl = 1'b0;
    ivl_q    = '0;
    jit_q    = '0;
    have_dly = 1'b0;
    dly_us   = '0;
  endfunction

  // Advance the mirror by one accepted beat and return the result it implies.
  function automatic estimate_t compute_estimate(logic clear, logic [31:0] t);
    logic [31:0] gap;
    logic [63:0] gap_c, gap_q, thr, thr_abs, mag, tgt, max_step, delta;
    cls_t        cls;
    estimate_t   e;
    cls = CLS_MEASURED;
    if (clear) begin
      have_last = 1'b0;
      last_t    = '0;
      forget_estimates();
      cls = CLS_CLEARED;
    end else if (!have_last) begin
      have_last = 1'b1;
      last_t    = t;
      cls = CLS_BASELINE;
    end else begin
      gap = t - last_t;
      // zero or wrapped-negative difference: duplicate or late packet
      if (gap == '0 || gap[31]) begin
        cls = CLS_IGNORED;
      end else begin
        gap_c = 64'(gap);
        if (gap_c > GAP_CAP) gap_c = GAP_CAP;
        if (have_ivl) begin
          thr     = (64'(live_cfg.stall_mult) * ivl_q) >> 8;
          thr_abs = 64'(live_cfg.stall_abs) << FB;
          if (thr_abs > thr) thr = thr_abs;
          if ((gap_c << FB) > thr) begin
            last_t = t;
            forget_estimates();
            cls = CLS_STALL;
          end
        end
        if (cls != CLS_STALL) begin
          last_t = t;
          gap_q  = (gap_c > US_LIM ? US_LIM : gap_c) << FB;
          if (!have_ivl) begin
            ivl_q    = gap_q;
            jit_q    = '0;
            have_ivl = 1'b1;
          end else begin
            mag   = gap_q >= ivl_q ? gap_q - ivl_q : ivl_q - gap_q;
            ivl_q = smooth_toward(ivl_q, gap_q);
            jit_q = smooth_toward(jit_q, mag);
          end
          if (ivl_q > Q_LIM) ivl_q = Q_LIM;
          if (jit_q > Q_LIM) jit_q = Q_LIM;

          // target = interval + gain * jitter, clamped; min wins the low side
          tgt = (ivl_q + ((64'(live_cfg.jgain) * jit_q) >> 8)) >> FB;
          if (tgt < 64'(live_cfg.min_delay)) tgt = 64'(live_cfg.min_delay);
          else if (tgt > 64'(live_cfg.max_delay)) tgt = 64'(live_cfg.max_delay);

          if (!have_dly) begin
            dly_us   = tgt;
            have_dly = 1'b1;
          end else begin
            // slew limit: max(min_delay, step_frac * interval)
            max_step = scale_q16(live_cfg.step_frac, ivl_q) >> FB;
            if (max_step < 64'(live_cfg.min_delay)) max_step = 64'(live_cfg.min_delay);
            if (tgt >= dly_us) begin
              delta  = tgt - dly_us;
              dly_us = dly_us + (delta > max_step ? max_step : delta);
            end else begin
              delta  = dly_us - tgt;
              dly_us = dly_us - (delta > max_step ? max_step : delta);
            end
          end
          dly_us = dly_us & US_LIM;
        end
      end
    end
    e.delay    = have_dly ? dly_us[23:0] : live_cfg.anchor;
    e.valid    = have_dly;
    e.interval = have_ivl ? ivl_q[FB +: 24] : '0;
    e.jitter   = have_ivl ? jit_q[FB +: 24] : '0;
    e.cls      = cls;
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, receiver back-pressure, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ready toggles on the falling edge; idle probability per cycle
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Monitors: every accepted arrival beat feeds the mirror; every result beat
  // is compared against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      expected_estimates.push_back(compute_estimate(in_tuser[0], in_tdata[31:0]));
  end

  always @(posedge clk) begin
    estimate_t exp_e;
    estimate_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.delay    = out_tdata[23:0];
      got.interval = out_tdata[47:24];
      got.jitter   = out_tdata[71:48];
      got.valid    = out_tuser[0];
      got.cls      = cls_t'(out_tuser[3:1]);
      if (expected_estimates.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result beat: expected none, got %h", $time, got);
      end else begin
        exp_e = expected_estimates.pop_front();
        if (exp_e.cls <= CLS_CLEARED) class_seen[exp_e.cls]++;
        if (got.delay !== exp_e.delay) begin
          mismatches++;
          $display("%0t delay_us: expected %0d, got %0d", $time, exp_e.delay, got.delay);
        end
        if (got.valid !== exp_e.valid) begin
          mismatches++;
          $display("%0t delay_valid: expected %0b, got %0b", $time, exp_e.valid, got.valid);
        end
        if (got.interval !== exp_e.interval) begin
          mismatches++;
          $display("%0t interval_us: expected %0d, got %0d", $time, exp_e.interval,
                   got.interval);
        end
        if (got.jitter !== exp_e.jitter) begin
          mismatches++;
          $display("%0t jitter_us: expected %0d, got %0d", $time, exp_e.jitter, got.jitter);
        end
        if (got.cls !== exp_e.cls) begin
          mismatches++;
          $display("%0t arrival_class: expected %0d, got %0d", $time, exp_e.cls, got.cls);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers (all called at a falling edge, all return at one)
  // ---------------------------------------------------------------------------

  // One arrival or clear beat. tvalid stays high on return so back-to-back
  // beats need no low cycle; drain_results drops it.
  task automatic send_arrival(logic clear, logic [31:0] t);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = clear;
    in_tdata  = IN_DW'(t);
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    beats_sent++;
    // next generated timestamp builds on what the block now holds
    stream_t = have_last ? last_t : t;
  endtask

  // Wait until every predicted beat has come back, then keep waiting so
  // a stray extra beat would still show up.
  task automatic drain_results();
    in_tvalid = 1'b0;
    while (expected_estimates.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  // APB write: setup, then access until pready; mirror updates on the same edge.
  task automatic cfg_write(reg_idx_t idx, logic [23:0] value);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = CFG_DW'(value);
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_STALL_MULT: live_cfg.stall_mult = value[11:0];
      REG_STALL_ABS:  live_cfg.stall_abs  = value;
      REG_ALPHA:      live_cfg.alpha      = value[15:0];
      REG_JGAIN:      live_cfg.jgain      = value[11:0];
      REG_MIN_DELAY:  live_cfg.min_delay  = value;
      REG_MAX_DELAY:  live_cfg.max_delay  = value;
      REG_STEP_FRAC:  live_cfg.step_frac  = value[15:0];
      REG_ANCHOR:     live_cfg.anchor     = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // Rewrite all eight registers; only ever called with the block drained.
  task automatic apply_profile(cfg_profile_t prof);
    logic [23:0] v[8];
    case (prof)
      PROF_ZERO: v = '{default: '0};
      PROF_FULL: v = '{24'hFFF, 24'hFF_FFFF, 24'hFFFF, 24'hFFF,
                       24'hFF_FFFF, 24'hFF_FFFF, 24'hFFFF, 24'hFF_FFFF};
      PROF_INVERTED: v = '{CFG_RST_STALL_MULT, CFG_RST_STALL_ABS, CFG_RST_ALPHA,
                           CFG_RST_JGAIN, 24'd200000, 24'd50000, CFG_RST_STEP_FRAC,
                           CFG_RST_ANCHOR};
      PROF_RANDOM: begin
        v[REG_STALL_MULT] = 24'($urandom_range(4095));
        // mostly realistic stall limits, sometimes anywhere in range
        v[REG_STALL_ABS]  = 24'($urandom_range(3) == 0 ? $urandom_range(24'hFF_FFFF)
                                                       : $urandom_range(50000, 4000000));
        v[REG_ALPHA]      = 24'($urandom_range(16'hFFFF));
        v[REG_JGAIN]      = 24'($urandom_range(4095));
        v[REG_MIN_DELAY]  = 24'($urandom_range(200000));
        v[REG_MAX_DELAY]  = 24'($urandom_range(1) ? $urandom_range(24'hFF_FFFF)
                                                  : $urandom_range(100000, 2000000));
        v[REG_STEP_FRAC]  = 24'($urandom_range(16'hFFFF));
        v[REG_ANCHOR]     = 24'($urandom_range(24'hFF_FFFF));
      end
      default: v = '{CFG_RST_STALL_MULT, CFG_RST_STALL_ABS, CFG_RST_ALPHA, CFG_RST_JGAIN,
                     CFG_RST_MIN_DELAY, CFG_RST_MAX_DELAY, CFG_RST_STEP_FRAC,
                     CFG_RST_ANCHOR};
    endcase
    drain_results();
    for (int i = 0; i < 8; i++) cfg_write(reg_idx_t'(i), v[i]);
    profiles_applied++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // clear with nothing held, then baselines at both ends of the time range
  task automatic test_clear_and_baseline();
    send_arrival(1'b1, 32'hFFFF_FFFF);
    send_arrival(1'b0, 32'h0000_0000);
    send_arrival(1'b1, 32'h0000_0000);
    send_arrival(1'b0, 32'hFFFF_FFF0);
  endtask

  // duplicate, older, and exactly half the wrap ahead: all dropped
  task automatic test_ignored_arrivals();
    send_arrival(1'b0, 32'hFFFF_FFF0);
    send_arrival(1'b0, 32'hFFFF_FF00);
    send_arrival(1'b0, 32'h7FFF_FFF0);
  endtask

  // steady stream across the timestamp wrap, a stall, then a fresh interval
  task automatic test_measured_and_stall();
    logic [31:0] t;
    t = 32'hFFFF_FFF0 + 32'd20000;
    send_arrival(1'b0, t);
    t += 32'd21000;  send_arrival(1'b0, t);
    t += 32'd19500;  send_arrival(1'b0, t);
    t += 32'd20200;  send_arrival(1'b0, t);
    t += 32'd600000; send_arrival(1'b0, t);
    t += 32'd20000;  send_arrival(1'b0, t);
    t += 32'd22000;  send_arrival(1'b0, t);
  endtask

  // largest forward gap saturates the interval; repeating it is a stall
  task automatic test_huge_gap();
    send_arrival(1'b1, 32'h5A5A_A5A5);
    send_arrival(1'b0, 32'h0000_0000);
    send_arrival(1'b0, 32'h7FFF_FFFF);
    send_arrival(1'b0, 32'hFFFF_FFFE);
    send_arrival(1'b0, 32'hFFFF_FFFF);
  endtask

  // min above max: target pinned, block must not misbehave
  task automatic test_inverted_clamps();
    apply_profile(PROF_INVERTED);
    send_arrival(1'b1, 32'h0000_1234);
    send_arrival(1'b0, 32'd1000);
    send_arrival(1'b0, 32'd21000);
    send_arrival(1'b0, 32'd41000);
    apply_profile(PROF_DEFAULT);
  endtask

  // Bursts of 40 beats, each under its own register profile. Mostly a
  // well-formed stream around a nominal interval; the rest is clears,
  // duplicates, late packets, stall-sized gaps and random timestamps.
  task automatic test_random_traffic(int n_items);
    int          done;
    int          burst;
    int          r;
    int          span;
    logic [31:0] nominal;
    done  = 0;
    burst = 0;
    while (done < n_items) begin
      case (burst)
        0:       apply_profile(PROF_ZERO);
        1:       apply_profile(PROF_FULL);
        2:       apply_profile(PROF_INVERTED);
        3:       apply_profile(PROF_DEFAULT);
        default: apply_profile(PROF_RANDOM);
      endcase
      case ($urandom_range(2))
        0:       nominal = $urandom_range(1, 64);
        1:       nominal = $urandom_range(5000, 40000);
        default: nominal = $urandom_range(100000, 20000000);
      endcase
      span = int'(nominal / 4) + 1;
      repeat (40) begin
        r = $urandom_range(99);
        if (r < 4)       send_arrival(1'b1, $urandom);
        else if (r < 8)  send_arrival(1'b0, stream_t);
        else if (r < 12) send_arrival(1'b0, stream_t - $urandom_range(1, 32'h7FFF_FFFF));
        else if (r < 15) send_arrival(1'b0, stream_t + $urandom_range(1 << 20, 32'h7FFF_FFFF));
        else if (r < 18) send_arrival(1'b0, $urandom);
        else send_arrival(1'b0, stream_t + nominal + $urandom_range(span) - span / 2);
        done++;
      end
      burst++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part at reset defaults, no idling
    test_clear_and_baseline();
    test_ignored_arrivals();
    test_measured_and_stall();
    test_huge_gap();
    test_inverted_clamps();

    // sender sparse / receiver choked, then swapped, then full rate
    src_idle_pct = 36;
    snk_idle_pct = 66;
    test_random_traffic(400);
    src_idle_pct = 66;
    snk_idle_pct = 36;
    test_random_traffic(400);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_traffic(400);

    drain_results();
    $display("Sent %0d beats under %0d register profiles, both sides idling and at full rate.",
             beats_sent, profiles_applied);
    $display("Results by class: %0d baseline, %0d ignored, %0d stall, %0d measured, %0d clear.",
             class_seen[CLS_BASELINE], class_seen[CLS_IGNORED], class_seen[CLS_STALL],
             class_seen[CLS_MEASURED], class_seen[CLS_CLEARED]);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/apde_pkg.sv
rtl/core/apde_regs.sv
rtl/core/apde_ctrl.sv
rtl/core/apde_dp.sv
rtl/core/adaptive_playout_delay_estimator_core.sv
dv/tb_adaptive_playout_delay_estimator_core.sv
